FILE: rtl/core/tls_pkg.sv
package tls_pkg;

  // Field and datapath widths.
  localparam int unsigned COORD_W = 32;
  localparam int unsigned SIZE_W  = 31;
  localparam int unsigned DIFF_W  = COORD_W + 1;
  localparam int unsigned SQ_W    = 2 * DIFF_W;
  localparam int unsigned SUM_W   = SQ_W;
  localparam int unsigned RAD_W   = 32;
  localparam int unsigned LHS_W   = RAD_W + 10;
  localparam int unsigned ROOT_W  = 34;
  localparam int unsigned SQ_STEPS = ROOT_W;
  localparam int unsigned RADICAND_W = 2 * ROOT_W;
  localparam int unsigned REM_W   = ROOT_W + 2;
  localparam int unsigned DEN_W   = ROOT_W + 16;
  localparam int unsigned THR_W   = DEN_W + 9;
  localparam int unsigned BANDS   = 5;

  // Fixed-point constants; the cosine, 1/sqrt2 and half-FOV tangent factors are Q0.16.
  localparam logic [15:0] COS30_Q16    = 16'd56753;
  localparam logic [15:0] INV_SQRT2_Q16 = 16'd46334;
  localparam logic [15:0] TAN_HALF_FOV_Q16 = 16'd37829;
  localparam logic [9:0]  SCREEN_PX    = 10'd1000;
  localparam logic [RAD_W-1:0] UNIT_RADIUS = 32'h0001_0000;
  localparam logic [6:0]  MIN_SEGMENTS = 7'd3;
  localparam logic [6:0]  MIN_ROUND_SEGMENTS = 7'd4;
  localparam logic [6:0]  MAX_SEGMENTS = 7'd64;
  localparam logic [6:0]  CUBE_SEGMENTS = 7'd1;
  localparam logic [15:0] QUALITY_RESET = 16'd256;

  // Configuration register indexes.
  localparam logic [1:0] CFG_CAMERA_X = 2'd0;
  localparam logic [1:0] CFG_CAMERA_Y = 2'd1;
  localparam logic [1:0] CFG_CAMERA_Z = 2'd2;
  localparam logic [1:0] CFG_QUALITY  = 2'd3;

  // Primitive type codes.
  typedef enum logic [2:0] {
    PRIM_SPHERE   = 3'd0,
    PRIM_CUBE     = 3'd1,
    PRIM_CYLINDER = 3'd2,
    PRIM_CONE     = 3'd3,
    PRIM_CAPSULE  = 3'd4,
    PRIM_PLANE    = 3'd5
  } prim_t;

  // Per-request data that rides alongside the square root pipeline.
  typedef struct packed {
    logic [2:0]       prim_type;
    logic [LHS_W-1:0] lhs;
  } tls_side_t;

  typedef struct packed {
    logic      valid;
    tls_side_t side;
  } tls_ctrl_t;

  // Apparent-height thresholds in pixels, ascending.
  function automatic logic [8:0] band_limit(input logic [2:0] idx);
    logic [8:0] lim;
    unique case (idx)
      3'd0:    lim = 9'd20;
      3'd1:    lim = 9'd50;
      3'd2:    lim = 9'd100;
      3'd3:    lim = 9'd200;
      default: lim = 9'd500;
    endcase
    return lim;
  endfunction

  // Base segment count for each size band.
  function automatic logic [5:0] band_segs(input logic [2:0] band);
    logic [5:0] segs;
    unique case (band)
      3'd0:    segs = 6'd4;
      3'd1:    segs = 6'd8;
      3'd2:    segs = 6'd12;
      3'd3:    segs = 6'd16;
      3'd4:    segs = 6'd24;
      default: segs = 6'd32;
    endcase
    return segs;
  endfunction

endpackage

FILE: rtl/core/tls_sqrt.sv
module tls_sqrt import tls_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  tls_ctrl_t               ctrl_in,
  input  logic [SUM_W-1:0]        radicand,
  output tls_ctrl_t               ctrl_out,
  output logic [ROOT_W-1:0]       root
);

  // Stage registers, one result bit per stage.
  logic [REM_W-1:0]      rem_q    [SQ_STEPS];
  logic [ROOT_W-1:0]     root_q   [SQ_STEPS];
  logic [RADICAND_W-1:0] rad_q    [SQ_STEPS];
  tls_ctrl_t             ctrl_q   [SQ_STEPS];

  // Stage inputs and next values.
  logic [REM_W-1:0]      rem_src  [SQ_STEPS];
  logic [ROOT_W-1:0]     root_src [SQ_STEPS];
  logic [RADICAND_W-1:0] rad_src  [SQ_STEPS];
  tls_ctrl_t             ctrl_src [SQ_STEPS];
  logic [REM_W+1:0]      cur      [SQ_STEPS];
  logic [REM_W+1:0]      trial    [SQ_STEPS];
  logic [REM_W+1:0]      diff     [SQ_STEPS];
  logic                  take     [SQ_STEPS];
  logic [REM_W-1:0]      rem_next [SQ_STEPS];
  logic [ROOT_W-1:0]     root_next[SQ_STEPS];

  // Digit-by-digit square root: bring down two radicand bits, try root*4+1.
  always_comb begin
    for (int k = 0; k < SQ_STEPS; k++) begin
      if (k == 0) begin
        rem_src[k]  = '0;
        root_src[k] = '0;
        rad_src[k]  = {{(RADICAND_W-SUM_W){1'b0}}, radicand};
        ctrl_src[k] = ctrl_in;
      end else begin
        rem_src[k]  = rem_q[k-1];
        root_src[k] = root_q[k-1];
        rad_src[k]  = rad_q[k-1];
        ctrl_src[k] = ctrl_q[k-1];
      end
      cur[k]   = {rem_src[k], rad_src[k][RADICAND_W-1 -: 2]};
      trial[k] = {2'b00, root_src[k], 2'b01};
      diff[k]  = cur[k] - trial[k];
      take[k]  = (cur[k] >= trial[k]);
      rem_next[k]  = take[k] ? diff[k][REM_W-1:0] : cur[k][REM_W-1:0];
      root_next[k] = {root_src[k][ROOT_W-2:0], take[k]};
    end
  end

  // Valid bits reset; the arithmetic payload does not need to.
  always_ff @(posedge clk) begin
    for (int k = 0; k < SQ_STEPS; k++) begin
      rem_q[k]  <= rem_next[k];
      root_q[k] <= root_next[k];
      rad_q[k]  <= {rad_src[k][RADICAND_W-3:0], 2'b00};
      ctrl_q[k].side <= ctrl_src[k].side;
      if (rst) begin
        ctrl_q[k].valid <= 1'b0;
      end else begin
        ctrl_q[k].valid <= ctrl_src[k].valid;
      end
    end
  end

  assign ctrl_out = ctrl_q[SQ_STEPS-1];
  assign root     = root_q[SQ_STEPS-1];

endmodule

FILE: rtl/core/tessellation_level_select.sv
// Tessellation level select: takes one primitive request per clock cycle and
// returns its segment count and apparent size band at the end of the pipeline.
// The pipeline depth is set by the distance square root, which resolves
// one root bit per pipeline stage (34 stages), plus three stages in front for
// the coordinate differences, squares and sum and four behind for the
// threshold products, band compare and final count. Busy is always low, and
// done pulses for exactly one cycle with each result: the receiver cannot
// stall the block, so results must be taken when they appear. Camera and
// quality registers are sampled live by the pipeline, so write them only
// when no request is in flight.
module tessellation_level_select import tls_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic                      cfg_write,
  input  logic [1:0]                cfg_index,
  input  logic [COORD_W-1:0]        cfg_data,
  input  logic [2:0]                prim_type,
  input  logic signed [COORD_W-1:0] center_x,
  input  logic signed [COORD_W-1:0] center_y,
  input  logic signed [COORD_W-1:0] center_z,
  input  logic [SIZE_W-1:0]         size_a,
  input  logic [SIZE_W-1:0]         size_b,
  output logic                      done,
  output logic [6:0]                segments,
  output logic [2:0]                size_band
);

  // Configuration registers.
  logic signed [COORD_W-1:0] camera_x;
  logic signed [COORD_W-1:0] camera_y;
  logic signed [COORD_W-1:0] camera_z;
  logic [15:0]               quality_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      camera_x      <= '0;
      camera_y      <= '0;
      camera_z      <= '0;
      quality_scale <= QUALITY_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_CAMERA_X: camera_x <= cfg_data;
        CFG_CAMERA_Y: camera_y <= cfg_data;
        CFG_CAMERA_Z: camera_z <= cfg_data;
        CFG_QUALITY:  quality_scale <= cfg_data[15:0];
        default:      camera_x <= camera_x;
      endcase
    end
  end

  // The pipeline never stalls, so a request is taken every cycle.
  assign busy = 1'b0;

  // Stage 1: absolute coordinate differences and bounding radius.
  logic [DIFF_W-1:0] diff_x, diff_y, diff_z;
  logic [DIFF_W-1:0] abs_x, abs_y, abs_z;
  logic [SIZE_W-1:0] half_b, max_ab, max_a_half;
  logic [SIZE_W+15:0] rad_prod;
  logic [RAD_W-1:0]  rad_next;

  always_comb begin
    diff_x = {center_x[COORD_W-1], center_x} - {camera_x[COORD_W-1], camera_x};
    diff_y = {center_y[COORD_W-1], center_y} - {camera_y[COORD_W-1], camera_y};
    diff_z = {center_z[COORD_W-1], center_z} - {camera_z[COORD_W-1], camera_z};
    abs_x  = diff_x[DIFF_W-1] ? (~diff_x + 1'b1) : diff_x;
    abs_y  = diff_y[DIFF_W-1] ? (~diff_y + 1'b1) : diff_y;
    abs_z  = diff_z[DIFF_W-1] ? (~diff_z + 1'b1) : diff_z;

    half_b     = size_b >> 1;
    max_ab     = (size_a > size_b) ? size_a : size_b;
    max_a_half = (size_a > half_b) ? size_a : half_b;

    // One shared multiplier covers the cube and plane scale factors.
    if (prim_type == PRIM_CUBE) begin
      rad_prod = size_a * COS30_Q16;
    end else begin
      rad_prod = max_ab * INV_SQRT2_Q16;
    end

    unique case (prim_type)
      PRIM_SPHERE:   rad_next = {1'b0, size_a};
      PRIM_CUBE,
      PRIM_PLANE:    rad_next = {1'b0, rad_prod[SIZE_W+15:16]};
      PRIM_CYLINDER,
      PRIM_CONE:     rad_next = {1'b0, max_a_half};
      PRIM_CAPSULE:  rad_next = {1'b0, half_b} + {1'b0, size_a};
      default:       rad_next = UNIT_RADIUS;
    endcase
  end

  logic              s1_valid;
  logic [2:0]        s1_type;
  logic [DIFF_W-1:0] s1_dx, s1_dy, s1_dz;
  logic [RAD_W-1:0]  s1_rad;

  always_ff @(posedge clk) begin
    s1_type <= prim_type;
    s1_dx   <= abs_x;
    s1_dy   <= abs_y;
    s1_dz   <= abs_z;
    s1_rad  <= rad_next;
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start;
    end
  end

  // Stage 2: squares and the scaled radius.
  logic             s2_valid;
  logic [2:0]       s2_type;
  logic [SQ_W-1:0]  s2_sx, s2_sy, s2_sz;
  logic [LHS_W-1:0] s2_lhs;

  always_ff @(posedge clk) begin
    s2_type <= s1_type;
    s2_sx   <= s1_dx * s1_dx;
    s2_sy   <= s1_dy * s1_dy;
    s2_sz   <= s1_dz * s1_dz;
    s2_lhs  <= s1_rad * SCREEN_PX;
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  // Stage 3: squared distance.
  tls_ctrl_t        s3_ctrl;
  logic [SUM_W-1:0] s3_sum;

  always_ff @(posedge clk) begin
    s3_sum              <= s2_sx + s2_sy + s2_sz;
    s3_ctrl.side.prim_type <= s2_type;
    s3_ctrl.side.lhs    <= s2_lhs;
    if (rst) begin
      s3_ctrl.valid <= 1'b0;
    end else begin
      s3_ctrl.valid <= s2_valid;
    end
  end

  // Distance by a pipelined integer square root.
  tls_ctrl_t         sq_ctrl;
  logic [ROOT_W-1:0] distance;

  tls_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .ctrl_in  (s3_ctrl),
    .radicand (s3_sum),
    .ctrl_out (sq_ctrl),
    .root     (distance)
  );

  // Stage 4: distance times the half-FOV tangent.
  tls_ctrl_t        s4_ctrl;
  logic [DEN_W-1:0] s4_den;

  always_ff @(posedge clk) begin
    s4_den        <= distance * TAN_HALF_FOV_Q16;
    s4_ctrl.side  <= sq_ctrl.side;
    if (rst) begin
      s4_ctrl.valid <= 1'b0;
    end else begin
      s4_ctrl.valid <= sq_ctrl.valid;
    end
  end

  // Stage 5: one threshold product per band boundary.
  tls_ctrl_t        s5_ctrl;
  logic [THR_W-1:0] s5_thr [BANDS];

  always_ff @(posedge clk) begin
    for (int i = 0; i < BANDS; i++) begin
      s5_thr[i] <= s4_den * band_limit(3'(i));
    end
    s5_ctrl.side <= s4_ctrl.side;
    if (rst) begin
      s5_ctrl.valid <= 1'b0;
    end else begin
      s5_ctrl.valid <= s4_ctrl.valid;
    end
  end

  // Stage 6: size band. A zero distance clears every threshold, giving the top band.
  logic [LHS_W+15:0] lhs_full;
  logic [2:0]        band_next;

  always_comb begin
    lhs_full  = {s5_ctrl.side.lhs, 16'h0000};
    band_next = 3'd0;
    for (int i = 0; i < BANDS; i++) begin
      if (band_next == 3'(i) && {1'b0, lhs_full} >= {1'b0, s5_thr[i]}) begin
        band_next = 3'(i + 1);
      end
    end
  end

  logic       s6_valid;
  logic [2:0] s6_type;
  logic [2:0] s6_band;

  always_ff @(posedge clk) begin
    s6_type <= s5_ctrl.side.prim_type;
    s6_band <= band_next;
    if (rst) begin
      s6_valid <= 1'b0;
    end else begin
      s6_valid <= s5_ctrl.valid;
    end
  end

  // Stage 7: scale by quality, clamp, apply per-type limits.
  logic [21:0] scaled;
  logic [13:0] scaled_int;
  logic [6:0]  segs_next;

  always_comb begin
    scaled     = band_segs(s6_band) * quality_scale;
    scaled_int = scaled[21:8];
    if (scaled_int < 14'(MIN_SEGMENTS)) begin
      segs_next = MIN_SEGMENTS;
    end else if (scaled_int > 14'(MAX_SEGMENTS)) begin
      segs_next = MAX_SEGMENTS;
    end else begin
      segs_next = scaled_int[6:0];
    end
    unique case (s6_type)
      PRIM_SPHERE,
      PRIM_CYLINDER,
      PRIM_CONE,
      PRIM_CAPSULE: begin
        if (segs_next < MIN_ROUND_SEGMENTS) begin
          segs_next = MIN_ROUND_SEGMENTS;
        end
      end
      PRIM_CUBE:    segs_next = CUBE_SEGMENTS;
      default:      segs_next = segs_next;
    endcase
  end

  always_ff @(posedge clk) begin
    segments  <= segs_next;
    size_band <= s6_band;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s6_valid;
    end
  end

endmodule
